// ----- hdl/mwm_pkg.sv -----
// Package for the multichannel window median unit: payload structs,
// register codes, reset values and field packing helpers.
// No dependencies.
`default_nettype none

package mwm_pkg;

  // sample width and number of sensor fields in one transfer
  localparam int unsigned DataW = 16;
  localparam int unsigned NumSensors = 10;

  // default sizing handed to the top level parameters
  localparam int unsigned WindowDepthDef = 5;
  localparam int unsigned ChannelsDef = 10;

  // configuration register reset values
  localparam logic [2:0]       WlReset = 3'd5;
  localparam logic [DataW-1:0] EmptyReset = 16'd10000;

  // operation codes of an input transfer
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_EMPTY_VALUE   = 1'b1
  } reg_e;

  typedef logic [NumSensors-1:0][DataW-1:0] sample_arr_t;

  typedef struct packed {
    op_e              opcode;
    logic [DataW-1:0] front_left;
    logic [DataW-1:0] front_center_left;
    logic [DataW-1:0] front_center;
    logic [DataW-1:0] front_center_right;
    logic [DataW-1:0] front_right;
    logic [DataW-1:0] side_left;
    logic [DataW-1:0] side_right;
    logic [DataW-1:0] rear_left;
    logic [DataW-1:0] rear_center;
    logic [DataW-1:0] rear_right;
  } in_item_t;

  typedef struct packed {
    logic             window_was_empty;
    logic [DataW-1:0] med_front_left;
    logic [DataW-1:0] med_front_center_left;
    logic [DataW-1:0] med_front_center;
    logic [DataW-1:0] med_front_center_right;
    logic [DataW-1:0] med_front_right;
    logic [DataW-1:0] med_side_left;
    logic [DataW-1:0] med_side_right;
    logic [DataW-1:0] med_rear_left;
    logic [DataW-1:0] med_rear_center;
    logic [DataW-1:0] med_rear_right;
  } out_item_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic push;  // shift a new frame into the chain
    logic load;  // copy own frame into the probe and clear ranks
    logic scan;  // rank against the probe and pass the probe on
  } ctrl_t;

  // sensor fields in channel order
  function automatic sample_arr_t unpack_samples(input in_item_t item);
    sample_arr_t arr;
    arr[0] = item.front_left;
    arr[1] = item.front_center_left;
    arr[2] = item.front_center;
    arr[3] = item.front_center_right;
    arr[4] = item.front_right;
    arr[5] = item.side_left;
    arr[6] = item.side_right;
    arr[7] = item.rear_left;
    arr[8] = item.rear_center;
    arr[9] = item.rear_right;
    return arr;
  endfunction

  // channel medians into the result struct
  function automatic out_item_t pack_medians(input logic empty, input sample_arr_t arr);
    out_item_t item;
    item.window_was_empty       = empty;
    item.med_front_left         = arr[0];
    item.med_front_center_left  = arr[1];
    item.med_front_center       = arr[2];
    item.med_front_center_right = arr[3];
    item.med_front_right        = arr[4];
    item.med_side_left          = arr[5];
    item.med_side_right         = arr[6];
    item.med_rear_left          = arr[7];
    item.med_rear_center        = arr[8];
    item.med_rear_right         = arr[9];
    return item;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mwm_cell.sv -----
// One cell of the window chain: holds one frame, a circulating probe and a
// rank counter per channel. Depends on mwm_pkg.
`default_nettype none

module mwm_cell #(
  parameter int unsigned WINDOW_DEPTH = mwm_pkg::WindowDepthDef,
  parameter int unsigned CHANNELS     = mwm_pkg::ChannelsDef,
  parameter int unsigned IDX          = 0,
  localparam int unsigned IdxW        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int unsigned CntW        = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire                                     clk_i,
  input  wire mwm_pkg::ctrl_t                     ctrl_i,
  input  wire [CntW-1:0]                          held_i,
  input  wire [CntW-1:0]                          half_i,
  input  wire [CHANNELS-1:0][mwm_pkg::DataW-1:0]  frame_i,
  output logic [CHANNELS-1:0][mwm_pkg::DataW-1:0] frame_o,
  input  wire [CHANNELS-1:0][mwm_pkg::DataW-1:0]  probe_val_i,
  input  wire [IdxW-1:0]                          probe_idx_i,
  output logic [CHANNELS-1:0][mwm_pkg::DataW-1:0] probe_val_o,
  output logic [IdxW-1:0]                         probe_idx_o,
  output logic [CHANNELS-1:0][mwm_pkg::DataW-1:0] sel_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);
  localparam logic [CntW-1:0] MyPos = CntW'(IDX);

  logic [CHANNELS-1:0][mwm_pkg::DataW-1:0] frame_q;
  logic [CHANNELS-1:0][mwm_pkg::DataW-1:0] probe_val_q;
  logic [IdxW-1:0]                         probe_idx_q;
  logic [CHANNELS-1:0][CntW-1:0]           rank_q;
  logic [CHANNELS-1:0][CntW-1:0]           rank_d;
  logic                                    own_valid;
  logic                                    probe_valid;

  // a slot is held when its age is below the fill count
  assign own_valid   = MyPos < held_i;
  assign probe_valid = CntW'(probe_idx_q) < held_i;

  // count held values that sort ahead of our own, ties broken by slot
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      rank_d[c] = rank_q[c];
      if (probe_valid && ((probe_val_q[c] < frame_q[c]) ||
                          ((probe_val_q[c] == frame_q[c]) && (probe_idx_q < MyIdx)))) begin
        rank_d[c] = rank_q[c] + CntW'(1);
      end
    end
  end

  // frame shift, probe ring and rank update
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      frame_q <= frame_i;
    end
    if (ctrl_i.load) begin
      probe_val_q <= frame_q;
      probe_idx_q <= MyIdx;
      rank_q      <= '0;
    end else if (ctrl_i.scan) begin
      probe_val_q <= probe_val_i;
      probe_idx_q <= probe_idx_i;
      rank_q      <= rank_d;
    end
  end

  // offer own value where it holds the median rank
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sel_o[c] = (own_valid && (rank_q[c] == half_i)) ? frame_q[c] : '0;
    end
  end

  assign frame_o     = frame_q;
  assign probe_val_o = probe_val_q;
  assign probe_idx_o = probe_idx_q;

endmodule

`default_nettype wire

// ----- hdl/multichannel_window_median_unit.sv -----
// Top level of the multichannel window median unit: configuration port,
// sequencer, chain of window cells and result register.
// Depends on mwm_pkg and mwm_cell.
//
// Usage
// - Input channel (in_valid_i/in_ready_o/in_data_i): a push transfer shifts a
//   frame of distance samples into the window; a query transfer asks for the
//   per-channel median of the frames held.
// - Output channel (out_valid_o/out_ready_i/out_data_o): one result per query.
// - A push does not leave the idle state, and the next transfer may follow at once.
// - A query passes through the sequencer states in order: it loads the probe
//   ring, then scans while every frame's probe travels once round the chain of
//   cells, then picks and registers the median once the output register is
//   free.
// - A finished result waits in the output register; new pushes are taken
//   meanwhile, and a later query holds its result until the register is free.
// - Reset empties the window and sets window_length 5, empty_value 10000.
//   Writing window_length also empties the window.
// - APB: pready is always high; window_length at 0x0, empty_value at 0x4.
`default_nettype none

module multichannel_window_median_unit #(
  parameter int unsigned WINDOW_DEPTH = mwm_pkg::WindowDepthDef,
  parameter int unsigned CHANNELS     = mwm_pkg::ChannelsDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire mwm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output mwm_pkg::out_item_t out_data_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned DW   = mwm_pkg::DataW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [IdxW-1:0]        cnt_q;
  logic [CntW-1:0]        held_q;
  logic [2:0]             wl_q;
  logic [DW-1:0]          empty_q;
  logic                   out_valid_q;
  mwm_pkg::out_item_t     out_q;
  mwm_pkg::out_item_t     out_d;

  logic                   cfg_wr;
  logic                   wl_wr;
  logic                   in_xfer;
  logic                   out_xfer;
  logic                   push_xfer;
  logic                   query_xfer;
  logic                   last_scan;
  logic                   out_free;
  logic [CntW-1:0]        wl_eff;
  logic [CntW-1:0]        half;
  mwm_pkg::ctrl_t         ctrl;
  mwm_pkg::sample_arr_t   in_arr;
  mwm_pkg::sample_arr_t   med_arr;

  logic [WINDOW_DEPTH-1:0][CHANNELS-1:0][DW-1:0] frame_w;
  logic [WINDOW_DEPTH-1:0][CHANNELS-1:0][DW-1:0] probe_val_w;
  logic [WINDOW_DEPTH-1:0][IdxW-1:0]             probe_idx_w;
  logic [WINDOW_DEPTH-1:0][CHANNELS-1:0][DW-1:0] sel_w;
  logic [CHANNELS-1:0][DW-1:0]                   new_frame;

  // handshakes
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign wl_wr      = cfg_wr && (mwm_pkg::reg_e'(paddr[2]) == mwm_pkg::REG_WINDOW_LENGTH);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  assign push_xfer  = in_xfer && (in_data_i.opcode == mwm_pkg::OP_PUSH);
  assign query_xfer = in_xfer && (in_data_i.opcode == mwm_pkg::OP_QUERY);
  assign last_scan  = (cnt_q == IdxW'(WINDOW_DEPTH - 1));
  assign out_free   = !out_valid_q || out_ready_i;

  // register readback
  assign pready = 1'b1;
  always_comb begin
    case (mwm_pkg::reg_e'(paddr[2]))
      mwm_pkg::REG_WINDOW_LENGTH: prdata = {29'd0, wl_q};
      mwm_pkg::REG_EMPTY_VALUE:   prdata = {16'd0, empty_q};
      default:                    prdata = '0;
    endcase
  end

  // effective window length, out-of-range values clamped
  always_comb begin
    if (wl_q == 3'd0) begin
      wl_eff = CntW'(1);
    end else if (32'(wl_q) > WINDOW_DEPTH) begin
      wl_eff = CntW'(WINDOW_DEPTH);
    end else begin
      wl_eff = CntW'(wl_q);
    end
  end

  assign half = held_q >> 1;

  // cell commands
  always_comb begin
    ctrl.push = push_xfer;
    ctrl.load = (state_q == ST_LOAD);
    ctrl.scan = (state_q == ST_SCAN);
  end

  // incoming frame for the head cell
  assign in_arr = mwm_pkg::unpack_samples(in_data_i);
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      new_frame[c] = in_arr[c];
    end
  end

  // chain of cells, frames shift forward, probes circulate as a ring
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    localparam int unsigned Prev = (k == 0) ? WINDOW_DEPTH - 1 : k - 1;
    mwm_cell #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .CHANNELS    (CHANNELS),
      .IDX         (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .held_i     (held_q),
      .half_i     (half),
      .frame_i    ((k == 0) ? new_frame : frame_w[Prev]),
      .frame_o    (frame_w[k]),
      .probe_val_i(probe_val_w[Prev]),
      .probe_idx_i(probe_idx_w[Prev]),
      .probe_val_o(probe_val_w[k]),
      .probe_idx_o(probe_idx_w[k]),
      .sel_o      (sel_w[k])
    );
  end

  // merge the cell offers, exactly one held cell per channel matches; an empty window gives empty_value
  always_comb begin
    med_arr = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        med_arr[c] = med_arr[c] | sel_w[k][c];
      end
      if (held_q == '0) begin
        med_arr[c] = empty_q;
      end
    end
    out_d = mwm_pkg::pack_medians(held_q == '0, med_arr);
  end

  // sequencer, window fill count, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      held_q      <= '0;
      wl_q        <= mwm_pkg::WlReset;
      empty_q     <= mwm_pkg::EmptyReset;
      out_valid_q <= 1'b0;
    end else begin
      // a result leaving frees the register unless the next one lands at once
      if (out_xfer && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (query_xfer) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + IdxW'(1);
          if (last_scan) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // a window length write empties the window and wins over a push
      if (push_xfer && !wl_wr) begin
        held_q <= (held_q >= wl_eff) ? wl_eff : held_q + CntW'(1);
      end
      if (cfg_wr) begin
        case (mwm_pkg::reg_e'(paddr[2]))
          mwm_pkg::REG_WINDOW_LENGTH: begin
            wl_q   <= pwdata[2:0];
            held_q <= '0;
          end
          mwm_pkg::REG_EMPTY_VALUE: begin
            empty_q <= pwdata[DW-1:0];
          end
          default: begin
            wl_q <= wl_q;
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill count never passes the effective window length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= wl_eff)
    else $error("window fill count above window length");

  // a query starts the probe load in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_xfer |=> (state_q == ST_LOAD))
    else $error("query transfer did not start the probe load");

  // the scan always starts from the first ring step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> ((state_q == ST_SCAN) && (cnt_q == '0)))
    else $error("scan did not start at step zero");

  // a push with no register write into a window that is not full grows it by one frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_xfer && !cfg_wr && (held_q < wl_eff)) |=> (held_q == $past(held_q) + CntW'(1)))
    else $error("push did not grow the window");

  // a finished query with room in the result register shows a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free) |=> out_valid_o)
    else $error("finished query left no result");

endmodule

`default_nettype wire
